>>> rtl/core/pufc_pkg.sv
// Package for the PCM underrun concealment block.
// Holds widths, constants and the command type shared by the front, queue and back.
// No dependencies.
package pufc_pkg;

    localparam int BLOCK_SAMPLES = 64;
    localparam int SAMPLE_W      = 16;
    localparam int POS_W         = 6;
    localparam int CNT_W         = 7;

    localparam int DIV_W     = ($clog2(BLOCK_SAMPLES + 1) > CNT_W) ?
                               $clog2(BLOCK_SAMPLES + 1) : CNT_W;
    localparam int NUM_W     = SAMPLE_W + DIV_W + 1;
    localparam int DIV_STEP  = 2;
    localparam int DIV_ITERS = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int QUO_W     = DIV_ITERS * DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);
    localparam int FADE_W    = $clog2(BLOCK_SAMPLES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_SAMPLE   = 1'b0;
    localparam logic ACT_UNDERRUN = 1'b1;

    typedef struct packed {
        logic                       is_fade;
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
        logic [DIV_W-1:0]           w_old;
        logic [DIV_W-1:0]           w_new;
        logic [DIV_W-1:0]           divisor;
    } t_cmd;

endpackage

>>> rtl/core/pufc_in_if.sv
// Input channel of the PCM underrun concealment block.
// Carries valid, ready and one input transaction; depends on pufc_pkg.
interface pufc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic signed [pufc_pkg::SAMPLE_W-1:0] pcm_in;
    logic [pufc_pkg::POS_W-1:0]           position;
    logic [pufc_pkg::CNT_W-1:0]           block_count;

    modport source (output valid, action, pcm_in, position, block_count, input ready);
    modport sink   (input valid, action, pcm_in, position, block_count, output ready);
endinterface

>>> rtl/core/pufc_out_if.sv
// Output channel of the PCM underrun concealment block.
// Carries valid, ready and one output transaction; depends on pufc_pkg.
interface pufc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pufc_pkg::SAMPLE_W-1:0] pcm_out;
    logic                                 run_end;

    modport source (output valid, pcm_out, run_end, input ready);
    modport sink   (input valid, pcm_out, run_end, output ready);
endinterface

>>> rtl/core/pcm_underrun_fade_crossfade_top.sv
// Top level of the PCM underrun concealment block.
// Ties together pufc_front, pufc_queue and pufc_back; depends on pufc_pkg and the channel interfaces.
//
// Usage: the input channel i_in carries one transaction per received sample (action 0,
// with pcm_in, position and block_count) or one underrun event (action 1). The output
// channel o_out carries pcm_out and run_end, which marks the last sample of a block or
// of a fade run. Both channels use a valid/ready handshake.
// An underrun produces 64 samples fading from the held sample to zero. Each faded sample
// passes through the multiply, scale-by-block-size and output states of the back end.
// A crossfaded sample in the first block after an underrun goes through a two-bit-per-cycle
// serial divider. A sample that passes unchanged goes from the idle state straight to the
// output state of the back end.
// A two-entry command queue lets the input side accept while the back end works.
// Reset clears the queue, the output register, the held sample and the recovery flag.
// When the receiver stalls, the result waits in the output register, the back end
// holds, and once the queue fills the input ready drops.
module pcm_underrun_fade_crossfade_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pufc_in_if.sink     i_in,
    pufc_out_if.source  o_out
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    pufc_pkg::t_cmd push_cmd;
    pufc_pkg::t_cmd head_cmd;

    pufc_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    pufc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    pufc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("Command pushed into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("Command popped from an empty queue.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("Output valid after reset.");
`endif

endmodule

>>> rtl/core/pufc_div.sv
// Serial signed divider, two quotient bits per cycle, truncating toward zero.
// Used by the back end for crossfade; depends on pufc_pkg.
module pufc_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pufc_pkg::NUM_W-1:0]    i_num,
    input  logic [pufc_pkg::DIV_W-1:0]           i_divisor,
    output logic                                 o_done,
    output logic signed [pufc_pkg::SAMPLE_W-1:0] o_quot
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [pufc_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [pufc_pkg::DIV_W-1:0]       r_rem, n_rem;
    logic [pufc_pkg::QUO_W-1:0]       r_quo, n_quo;
    logic [pufc_pkg::DIV_W-1:0]       r_divisor, n_divisor;
    logic                             r_neg, n_neg;

    logic [pufc_pkg::NUM_W-1:0]       mag;
    logic [pufc_pkg::DIV_W-1:0]       rem;
    logic [pufc_pkg::QUO_W-1:0]       quo;
    logic [pufc_pkg::DIV_W:0]         trial;
    logic [pufc_pkg::SAMPLE_W-1:0]    quo_lo;

    assign mag = i_num[pufc_pkg::NUM_W-1] ? (~i_num + 1'b1) : i_num;

    always_comb begin
        rem = r_rem;
        quo = r_quo;
        trial = '0;
        for (int b = 0; b < pufc_pkg::DIV_STEP; b++) begin
            trial = {rem, quo[pufc_pkg::QUO_W-1]};
            quo = {quo[pufc_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, r_divisor}) begin
                rem = pufc_pkg::DIV_W'(trial - {1'b0, r_divisor});
                quo[0] = 1'b1;
            end else begin
                rem = trial[pufc_pkg::DIV_W-1:0];
            end
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_divisor = r_divisor;
        n_neg     = r_neg;
        if (i_start) begin
            n_busy    = 1'b1;
            n_cnt     = pufc_pkg::DIV_CNT_W'(pufc_pkg::DIV_ITERS);
            n_rem     = '0;
            n_quo     = pufc_pkg::QUO_W'(mag);
            n_divisor = i_divisor;
            n_neg     = i_num[pufc_pkg::NUM_W-1];
        end else if (r_busy) begin
            n_rem = rem;
            n_quo = quo;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == pufc_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_divisor <= n_divisor;
        r_neg     <= n_neg;
    end

    assign quo_lo = r_quo[pufc_pkg::SAMPLE_W-1:0];
    assign o_quot = r_neg ? (~quo_lo + 1'b1) : quo_lo;
    assign o_done = r_done;

endmodule

>>> rtl/core/pufc_front.sv
// Front end: accepts input transactions and turns them into commands.
// Normalizes block length and position and works out the crossfade weights; depends on pufc_pkg.
module pufc_front (
    pufc_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output pufc_pkg::t_cmd  o_cmd
);

    logic [pufc_pkg::CNT_W-1:0] eff_cnt;
    logic [pufc_pkg::CNT_W-1:0] last_idx;
    logic [pufc_pkg::CNT_W-1:0] pos_ext;
    logic [pufc_pkg::CNT_W-1:0] idx;
    logic                       at_end;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    assign eff_cnt  = (i_in.block_count == '0) ? pufc_pkg::CNT_W'(1) : i_in.block_count;
    assign last_idx = eff_cnt - 1'b1;
    assign pos_ext  = pufc_pkg::CNT_W'(i_in.position);
    assign at_end   = (pos_ext >= last_idx);
    assign idx      = at_end ? last_idx : pos_ext;

    always_comb begin
        o_cmd.is_fade = (i_in.action == pufc_pkg::ACT_UNDERRUN);
        o_cmd.last    = at_end;
        o_cmd.sample  = i_in.pcm_in;
        o_cmd.w_old   = pufc_pkg::DIV_W'(last_idx - idx);
        o_cmd.w_new   = pufc_pkg::DIV_W'(idx + pufc_pkg::CNT_W'(1));
        o_cmd.divisor = pufc_pkg::DIV_W'(eff_cnt);
    end

endmodule

>>> rtl/core/pufc_queue.sv
// Short command queue between the front end and the back end.
// Register based first-in first-out store; depends on pufc_pkg.
module pufc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pufc_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pufc_pkg::t_cmd  o_cmd
);

    pufc_pkg::t_cmd                r_mem [pufc_pkg::QUEUE_DEPTH];
    logic [pufc_pkg::QPTR_W-1:0]   r_wp, n_wp;
    logic [pufc_pkg::QPTR_W-1:0]   r_rp, n_rp;
    logic [pufc_pkg::QCNT_W-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == pufc_pkg::QCNT_W'(pufc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == pufc_pkg::QPTR_W'(pufc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == pufc_pkg::QPTR_W'(pufc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/pufc_back.sv
// Back end: runs fade, crossfade and pass-through commands and drives the output register.
// Holds the held sample and recovery flag; uses pufc_div and pufc_pkg.
module pufc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  pufc_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    pufc_out_if.source      o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                               r_state, n_state;
    pufc_pkg::t_cmd                       r_cmd, n_cmd;
    logic [pufc_pkg::FADE_W-1:0]          r_k, n_k;
    logic signed [pufc_pkg::SAMPLE_W-1:0] r_held, n_held;
    logic                                 r_recov, n_recov;
    logic signed [pufc_pkg::NUM_W-1:0]    r_p1, n_p1;
    logic signed [pufc_pkg::NUM_W-1:0]    r_p2, n_p2;
    logic signed [pufc_pkg::SAMPLE_W-1:0] r_res, n_res;
    logic                                 r_ov, n_ov;
    logic signed [pufc_pkg::SAMPLE_W-1:0] r_out_pcm, n_out_pcm;
    logic                                 r_out_end, n_out_end;

    logic [pufc_pkg::DIV_W-1:0]           wa, wb, dv;
    logic signed [pufc_pkg::NUM_W-1:0]    held_x, smp_x, wa_x, wb_x, num;
    logic signed [pufc_pkg::SAMPLE_W-1:0] fade_q;
    logic                                 fade_last;
    logic                                 div_start;
    logic                                 div_done;
    logic signed [pufc_pkg::SAMPLE_W-1:0] div_quot;

    assign fade_last = (r_k == pufc_pkg::FADE_W'(pufc_pkg::BLOCK_SAMPLES - 1));
    assign wa = r_cmd.is_fade ?
                (pufc_pkg::DIV_W'(pufc_pkg::BLOCK_SAMPLES - 1) - pufc_pkg::DIV_W'(r_k)) :
                r_cmd.w_old;
    assign wb = r_cmd.is_fade ? '0 : r_cmd.w_new;
    assign dv = r_cmd.divisor;

    assign held_x = pufc_pkg::NUM_W'(r_held);
    assign smp_x  = pufc_pkg::NUM_W'(r_cmd.sample);
    assign wa_x   = $signed(pufc_pkg::NUM_W'(wa));
    assign wb_x   = $signed(pufc_pkg::NUM_W'(wb));
    assign num    = r_p1 + r_p2;
    assign fade_q = pufc_pkg::SAMPLE_W'(num / pufc_pkg::BLOCK_SAMPLES);

    pufc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num     (num),
        .i_divisor (dv),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_k       = r_k;
        n_held    = r_held;
        n_recov   = r_recov;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_res     = r_res;
        n_ov      = r_ov && !o_out.ready;
        n_out_pcm = r_out_pcm;
        n_out_end = r_out_end;
        o_pop     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_k   = '0;
                    if (!i_cmd.is_fade && !r_recov) begin
                        n_res   = i_cmd.sample;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_p1    = held_x * wa_x;
                n_p2    = smp_x * wb_x;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_cmd.is_fade) begin
                    n_res   = fade_q;
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov      = 1'b1;
                    n_out_pcm = r_res;
                    n_out_end = r_cmd.is_fade ? fade_last : r_cmd.last;
                    if (r_cmd.is_fade) begin
                        if (fade_last) begin
                            n_held  = '0;
                            n_recov = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_k     = r_k + 1'b1;
                            n_state = S_MUL;
                        end
                    end else begin
                        if (r_cmd.last) begin
                            n_held  = r_res;
                            n_recov = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_recov <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_recov <= n_recov;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_k       <= n_k;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_res     <= n_res;
        r_out_pcm <= n_out_pcm;
        r_out_end <= n_out_end;
    end

    assign o_out.valid   = r_ov;
    assign o_out.pcm_out = r_out_pcm;
    assign o_out.run_end = r_out_end;

endmodule

>>> test/pcm_underrun_fade_crossfade_top_test.sv
// Testbench for pcm_underrun_fade_crossfade_top: directed and random blocks and underruns,
// with a built-in predictor and an in-order result check under random stalls.
// Depends on pufc_pkg, pufc_in_if, pufc_out_if and the top level of the block.
module pcm_underrun_fade_crossfade_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 200;
    localparam int TAIL_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic                                 action;
        logic signed [pufc_pkg::SAMPLE_W-1:0] pcm;
        logic [pufc_pkg::POS_W-1:0]           pos;
        logic [pufc_pkg::CNT_W-1:0]           cnt;
    } t_pcm_item;

    typedef struct packed {
        logic signed [pufc_pkg::SAMPLE_W-1:0] pcm;
        logic                                 run_end;
    } t_pcm_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pufc_in_if  sample_ch ();
    pufc_out_if pcm_ch ();

    pcm_underrun_fade_crossfade_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (pcm_ch)
    );

    t_pcm_item   pending_items[$];
    t_pcm_result expected_pcm[$];

    logic signed [pufc_pkg::SAMPLE_W-1:0] held_sample = '0;
    logic                                 recovering  = 1'b0;

    logic failed         = 1'b0;
    logic quiet_tail     = 1'b0;
    logic long_hold_done = 1'b0;
    int   results_seen   = 0;
    int   send_gap       = 0;
    int   stall_left     = 0;
    int   long_hold_left = 0;
    int   idle_cycles    = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic predict_concealment(input t_pcm_item it);
        int          held;
        int          s;
        int          i;
        int          n;
        int          v;
        t_pcm_result r;
        held = held_sample;
        if (it.action == pufc_pkg::ACT_UNDERRUN) begin
            for (int k = 0; k < pufc_pkg::BLOCK_SAMPLES; k++) begin
                v = held * (pufc_pkg::BLOCK_SAMPLES - 1 - k) / pufc_pkg::BLOCK_SAMPLES;
                r.pcm = v[pufc_pkg::SAMPLE_W-1:0];
                r.run_end = (k == pufc_pkg::BLOCK_SAMPLES - 1);
                expected_pcm.push_back(r);
            end
            held_sample = '0;
            recovering = 1'b1;
        end else begin
            s = $signed(it.pcm);
            i = it.pos;
            n = it.cnt;
            if (n == 0) begin
                n = 1;
            end
            if (i > n - 1) begin
                i = n - 1;
            end
            if (recovering) begin
                v = (held * (n - 1 - i) + s * (i + 1)) / n;
            end else begin
                v = s;
            end
            r.pcm = v[pufc_pkg::SAMPLE_W-1:0];
            r.run_end = (i == n - 1);
            expected_pcm.push_back(r);
            if (r.run_end) begin
                held_sample = r.pcm;
                recovering = 1'b0;
            end
        end
    endtask

    task automatic add_sample(input int pcm, input int pos, input int cnt);
        t_pcm_item it;
        it.action = pufc_pkg::ACT_SAMPLE;
        it.pcm = pcm[pufc_pkg::SAMPLE_W-1:0];
        it.pos = pos[pufc_pkg::POS_W-1:0];
        it.cnt = cnt[pufc_pkg::CNT_W-1:0];
        pending_items.push_back(it);
    endtask

    task automatic add_underrun();
        t_pcm_item it;
        it.action = pufc_pkg::ACT_UNDERRUN;
        it.pcm = pufc_pkg::SAMPLE_W'($urandom);
        it.pos = pufc_pkg::POS_W'($urandom);
        it.cnt = pufc_pkg::CNT_W'($urandom);
        pending_items.push_back(it);
    endtask

    always @(posedge i_clk) begin
        t_pcm_item nxt;
        if (!i_rst_n) begin
            sample_ch.valid       <= 1'b0;
            sample_ch.action      <= pufc_pkg::ACT_SAMPLE;
            sample_ch.pcm_in      <= '0;
            sample_ch.position    <= '0;
            sample_ch.block_count <= '0;
            send_gap              <= 0;
        end else begin
            quiet_tail <= (pending_items.size() <= TAIL_ITEMS);
            if (sample_ch.valid && sample_ch.ready) begin
                nxt.action = sample_ch.action;
                nxt.pcm = sample_ch.pcm_in;
                nxt.pos = sample_ch.position;
                nxt.cnt = sample_ch.block_count;
                predict_concealment(nxt);
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    sample_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    sample_ch.valid       <= 1'b1;
                    sample_ch.action      <= nxt.action;
                    sample_ch.pcm_in      <= nxt.pcm;
                    sample_ch.position    <= nxt.pos;
                    sample_ch.block_count <= nxt.cnt;
                    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                        send_gap <= $urandom_range(1, 6);
                    end
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pcm_ch.ready   <= 1'b0;
            stall_left     <= 0;
            long_hold_left <= 0;
        end else if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
            pcm_ch.ready   <= 1'b0;
        end else if (!long_hold_done && results_seen >= 5) begin
            long_hold_done <= 1'b1;
            long_hold_left <= LONG_HOLD;
            pcm_ch.ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            pcm_ch.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 5);
            pcm_ch.ready <= 1'b0;
        end else begin
            pcm_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pcm_result want;
        if (i_rst_n && pcm_ch.valid && pcm_ch.ready) begin
            results_seen <= results_seen + 1;
            if (expected_pcm.size() == 0) begin
                $display("%0t: unexpected transaction pcm_out=%0d run_end=%0b",
                         $time, pcm_ch.pcm_out, pcm_ch.run_end);
                failed = 1'b1;
            end else begin
                want = expected_pcm.pop_front();
                if (pcm_ch.pcm_out !== want.pcm || pcm_ch.run_end !== want.run_end) begin
                    $display("%0t: expected pcm_out=%0d run_end=%0b, got pcm_out=%0d run_end=%0b",
                             $time, want.pcm, want.run_end, pcm_ch.pcm_out, pcm_ch.run_end);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((sample_ch.valid && sample_ch.ready) || (pcm_ch.valid && pcm_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int produced;
        int kind;
        int n;
        int stop;
        i_rst_n               = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.action      = pufc_pkg::ACT_SAMPLE;
        sample_ch.pcm_in      = '0;
        sample_ch.position    = '0;
        sample_ch.block_count = '0;
        pcm_ch.ready          = 1'b0;

        add_sample(32767, 0, 2);
        add_sample(-32768, 1, 2);
        add_underrun();
        add_underrun();
        add_sample(-32768, 0, 4);
        add_sample(32767, 1, 4);
        add_sample(-1, 2, 4);
        add_sample(12345, 3, 4);
        add_sample(1, 0, 0);
        add_underrun();
        add_sample(-32768, 5, 0);
        add_underrun();
        add_sample(32767, 63, 127);
        add_sample(-32768, 0, 127);
        add_sample(-32767, 63, 64);
        add_sample(21, 42, 10);
        add_sample(0, 0, 1);
        add_underrun();
        add_sample(-5, 0, 3);
        add_sample(7, 1, 3);
        add_sample(-32768, 2, 3);
        add_underrun();

        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                add_underrun();
                produced++;
            end else if (kind == 2) begin
                add_sample($urandom, $urandom_range(0, 63), $urandom_range(0, 127));
                produced++;
            end else begin
                n = (kind == 3) ? $urandom_range(9, 64) : $urandom_range(1, 8);
                stop = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
                for (int p = 0; p < stop; p++) begin
                    add_sample($urandom, p, n);
                end
                produced += stop;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || sample_ch.valid) @(posedge i_clk);
        while (expected_pcm.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
